// ===== hw/rtl/url_enc_pkg.sv =====
package url_enc_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [15:0] MAX_LEN_RST = 16'd1024;
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam logic [7:0] TERM_CHAR = 8'h00;

	// one queued job: the byte plus what the back end has to emit for it
	typedef struct packed {
		logic [7:0] data;
		logic esc;   // emit '%' and two hex digits
		logic chr;   // emit a character at all
		logic term;  // emit the terminator after the character(s)
	} desc_t;

	function automatic logic is_reserved(input logic [7:0] b);
		return b inside {8'h20, 8'h22, 8'h3c, 8'h3e, 8'h23, 8'h25, 8'h7b, 8'h7d,
			8'h7c, 8'h5c, 8'h5e, 8'h7e, 8'h5b, 8'h5d, 8'h60};
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h37 + {4'd0, nib};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/url_enc_ifs.sv =====
interface url_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic end_mark;
	modport source (output valid, output in_byte, output end_mark, input ready);
	modport sink (input valid, input in_byte, input end_mark, output ready);
endinterface

interface url_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic is_terminator;
	logic run_last;
	modport source (output valid, output out_byte, output is_terminator, output run_last,
		input ready);
	modport sink (input valid, input out_byte, input is_terminator, input run_last,
		output ready);
endinterface

interface url_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/url_enc_front.sv =====
module url_enc_front
	import url_enc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	url_in_if.sink in_ch,
	url_cfg_if.sink cfg,
	input logic fifo_full,
	output logic push,
	output desc_t push_desc
);

	logic [15:0] max_len_q;
	logic [16:0] cnt_q;
	logic trunc_q;

	logic acc;
	logic rsv;
	logic [1:0] add;
	logic [17:0] sum;
	logic [16:0] cnt_nxt;
	logic hit;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !fifo_full;
	assign acc = in_ch.valid && in_ch.ready;

	always_comb begin
		rsv = is_reserved(in_ch.in_byte);
		add = rsv ? 2'd3 : 2'd1;
		sum = {1'b0, cnt_q} + {16'd0, add};
		cnt_nxt = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[16:0];
		hit = ({1'b0, cnt_nxt} + 18'd5) > {2'd0, max_len_q};
	end

	always_comb begin
		push_desc.data = in_ch.in_byte;
		push_desc.esc = rsv && !in_ch.end_mark;
		push_desc.chr = !in_ch.end_mark;
		push_desc.term = in_ch.end_mark || hit;
		// once cut short the rest of the string, end marker included, emits nothing
		push = acc && !trunc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg.valid && cfg.ready) begin
			max_len_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			trunc_q <= 1'b0;
		end else if (acc) begin
			if (in_ch.end_mark) begin
				cnt_q <= '0;
				trunc_q <= 1'b0;
			end else if (!trunc_q) begin
				cnt_q <= cnt_nxt;
				trunc_q <= hit;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.end_mark |=> cnt_q == '0 && !trunc_q)
		else $error("end marker did not clear string state");

	a_trunc_silent: assert property (@(posedge clk) disable iff (!arst_n)
		trunc_q && !in_ch.end_mark && acc |=> trunc_q)
		else $error("truncation flag dropped inside a string");

endmodule

// ===== hw/rtl/url_enc_fifo.sv =====
module url_enc_fifo
	import url_enc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input desc_t din,
	output logic full,
	input logic pop,
	output desc_t dout,
	output logic empty
);

	localparam logic [FIFO_AW:0] FULL_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

	desc_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0] cnt_q;

	assign full = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[FIFO_AW-1:0] == (wr_q - rd_q))
		else $error("queue pointers out of step with fill count");

endmodule

// ===== hw/rtl/url_enc_back.sv =====
module url_enc_back
	import url_enc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input desc_t head,
	input logic empty,
	output logic pop,
	url_out_if.source out_ch
);

	desc_t cur_q;
	logic [1:0] step_q;
	logic busy_q;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_term_q;
	logic out_last_q;

	desc_t job;
	logic [1:0] step;
	logic [1:0] nchar;
	logic [2:0] total;
	logic last;
	logic adv;
	logic [7:0] res_byte;
	logic res_term;

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.is_terminator = out_term_q;
	assign out_ch.run_last = out_last_q;

	always_comb begin
		// work on the queue head directly when no job is in flight
		job = busy_q ? cur_q : head;
		step = busy_q ? step_q : 2'd0;
		nchar = job.esc ? 2'd3 : (job.chr ? 2'd1 : 2'd0);
		total = {1'b0, nchar} + {2'd0, job.term};
		last = ({1'b0, step} + 3'd1) == total;
		adv = (!out_valid_q || out_ch.ready) && (busy_q || !empty);
		pop = adv && !busy_q;
		res_term = 1'b0;
		if (step >= nchar) begin
			res_byte = TERM_CHAR;
			res_term = 1'b1;
		end else if (!job.esc) begin
			res_byte = job.data;
		end else begin
			case (step)
				2'd0: res_byte = PCT_CHAR;
				2'd1: res_byte = hex_digit(job.data[7:4]);
				default: res_byte = hex_digit(job.data[3:0]);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b1;
					step_q <= step + 1'b1;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (adv) begin
			out_byte_q <= res_byte;
			out_term_q <= res_term;
			out_last_q <= last;
		end
	end

	a_busy_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q != 2'd0 && {1'b0, step_q} < total)
		else $error("sequencer step outside the job");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_term |-> last)
		else $error("terminator not the last result of its job");

endmodule

// ===== hw/rtl/url_percent_encoder_top.sv =====
// channel   dir  handshake      payload
// in_ch     in   valid/ready    in_byte[7:0], end_mark
// out_ch    out  valid/ready    out_byte[7:0], is_terminator, run_last
// cfg       in   valid/ready    data[15:0] = max_len (ready always high)
//
// one result per cycle while out_ch is not stalled, from a single output register;
// an item gives 1 result for a plain byte, 3 for an escaped one, +1 with
// the terminator, 0 for items after truncation
// input is taken every cycle while the 4-entry job queue has room
// reset clears count, truncation flag, queue and output; max_len goes to 1024
// output stalls fill the queue and only then hold off input
module url_percent_encoder_top
	import url_enc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	url_in_if.sink in_ch,
	url_out_if.source out_ch,
	url_cfg_if.sink cfg
);

	logic push;
	desc_t push_desc;
	logic fifo_full;
	logic pop;
	desc_t head;
	logic empty;

	url_enc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg(cfg),
		.fifo_full(fifo_full),
		.push(push),
		.push_desc(push_desc)
	);

	url_enc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(push_desc),
		.full(fifo_full),
		.pop(pop),
		.dout(head),
		.empty(empty)
	);

	url_enc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule
